FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/tspqm_pkg.sv
// Shared constants for the task slot pool and queue manager.
// No dependencies; imported by the top level and the checker.
package tspqm_pkg;

  localparam int SLOTS_DEF = 16;

  localparam logic [2:0] ACT_ALLOC   = 3'd0;
  localparam logic [2:0] ACT_RELEASE = 3'd1;
  localparam logic [2:0] ACT_APP_RUN = 3'd2;
  localparam logic [2:0] ACT_APP_BLK = 3'd3;
  localparam logic [2:0] ACT_RM_RUN  = 3'd4;
  localparam logic [2:0] ACT_RM_BLK  = 3'd5;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd2;

endpackage

FILE: hdl/tspqm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tspqm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/task_slot_pool_queue_manager.sv
// Top level of the task slot pool and queue manager: sequencer, list heads, output register.
// Depends on tspqm_pkg and tspqm_ram.
//
// A pool of SLOTS task slots is threaded by one link RAM into a LIFO free
// list and two FIFO queues (run and blocked). Each request returns one
// result with a status and a slot. After reset the block writes the initial
// free-list chain into the link RAM and keeps in_tready low meanwhile. Each
// request is then handled alone: release, unused actions, rejected requests
// and append to an empty queue go straight to the result; allocate first
// reads the free head's link; append to a non-empty queue then links the old
// tail; remove from the queue head reads the head's link; remove further
// down walks the queue links (at most SLOTS), one link RAM read per cycle; a
// failed search ends there. The result waits in an output register; a new
// request is taken once it is loaded.
module task_slot_pool_queue_manager
  import tspqm_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [2:0] action, [6:3] slot, [7] zero
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [1:0] status, [5:2] slot_out, [7:6] zero
);

  localparam int LW = $clog2(SLOTS + 1);
  localparam int AW = $clog2(SLOTS);
  localparam int CW = (LW > 4) ? LW : 4;
  localparam logic [LW-1:0] NIL = LW'(SLOTS);

  localparam logic [3:0] ST_CLEAR    = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_ALLOC_RD = 4'd2;
  localparam logic [3:0] ST_APP_LINK = 4'd3;
  localparam logic [3:0] ST_RM_HEAD  = 4'd4;
  localparam logic [3:0] ST_RM_WALK  = 4'd5;
  localparam logic [3:0] ST_RM_SRD   = 4'd6;
  localparam logic [3:0] ST_RM_FIX   = 4'd7;
  localparam logic [3:0] ST_DONE     = 4'd8;

  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [LW-1:0] free_head_r, free_head_nxt;
  logic [LW-1:0] run_head_r, run_head_nxt;
  logic [LW-1:0] run_tail_r, run_tail_nxt;
  logic [LW-1:0] blk_head_r, blk_head_nxt;
  logic [LW-1:0] blk_tail_r, blk_tail_nxt;
  logic          qblk_r, qblk_nxt;
  logic [LW-1:0] slot_r, slot_nxt;
  logic [LW-1:0] cur_r, cur_nxt;
  logic [AW-1:0] steps_r, steps_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  logic [3:0]    res_slot_r, res_slot_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [3:0]    out_slot_r, out_slot_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [LW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [LW-1:0] ram_rdata;

  logic [2:0]    in_action;
  logic [3:0]    in_slot;
  logic [CW-1:0] slot_ext;
  logic          slot_ok;
  logic [LW-1:0] slot_link;
  logic          in_acc;
  logic          blk_sel;
  logic [LW-1:0] q_head;
  logic [LW-1:0] q_tail;
  logic [LW-1:0] q_head_nxt;
  logic [LW-1:0] q_tail_nxt;

  function automatic logic is_slot(input logic [LW-1:0] v);
    return v < NIL;
  endfunction

  tspqm_ram #(
    .WIDTH (LW),
    .DEPTH (SLOTS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_action = in_tdata[2:0];
  assign in_slot   = in_tdata[6:3];
  assign slot_ext  = CW'(in_slot);
  assign slot_ok   = slot_ext < CW'(SLOTS);
  assign slot_link = LW'(slot_ext);
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign blk_sel = (state_r == ST_IDLE)
                   ? ((in_action == ACT_APP_BLK) || (in_action == ACT_RM_BLK))
                   : qblk_r;
  assign q_head  = blk_sel ? blk_head_r : run_head_r;
  assign q_tail  = blk_sel ? blk_tail_r : run_tail_r;

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    free_head_nxt  = free_head_r;
    qblk_nxt       = qblk_r;
    slot_nxt       = slot_r;
    cur_nxt        = cur_r;
    steps_nxt      = steps_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    q_head_nxt     = q_head;
    q_tail_nxt     = q_tail;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = NIL;
    ram_raddr      = '0;

    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = LW'(clr_r) + LW'(1);
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          qblk_nxt       = blk_sel;
          slot_nxt       = slot_link;
          res_status_nxt = STATUS_OK;
          res_slot_nxt   = in_slot;
          state_nxt      = ST_DONE;
          if (in_action == ACT_ALLOC) begin
            if (is_slot(free_head_r)) begin
              res_slot_nxt = 4'(free_head_r);
              ram_raddr    = AW'(free_head_r);
              state_nxt    = ST_ALLOC_RD;
            end else begin
              res_status_nxt = STATUS_EMPTY;
              res_slot_nxt   = 4'd0;
            end
          end else if (in_action inside {[ACT_RELEASE:ACT_RM_BLK]}) begin
            if (!slot_ok) begin
              res_status_nxt = STATUS_NOTFOUND;
            end else begin
              case (in_action)
                ACT_RELEASE: begin
                  ram_we        = 1'b1;
                  ram_waddr     = AW'(slot_link);
                  ram_wdata     = free_head_r;
                  free_head_nxt = slot_link;
                end
                ACT_APP_RUN, ACT_APP_BLK: begin
                  ram_we    = 1'b1;
                  ram_waddr = AW'(slot_link);
                  ram_wdata = NIL;
                  if (!is_slot(q_head) || !is_slot(q_tail)) begin
                    q_head_nxt = slot_link;
                    q_tail_nxt = slot_link;
                  end else begin
                    state_nxt = ST_APP_LINK;
                  end
                end
                default: begin
                  if (!is_slot(q_head)) begin
                    res_status_nxt = STATUS_NOTFOUND;
                  end else if (q_head == slot_link) begin
                    ram_raddr = AW'(slot_link);
                    state_nxt = ST_RM_HEAD;
                  end else begin
                    ram_raddr = AW'(q_head);
                    cur_nxt   = q_head;
                    steps_nxt = '0;
                    state_nxt = ST_RM_WALK;
                  end
                end
              endcase
            end
          end
        end
      end
      ST_ALLOC_RD: begin
        free_head_nxt = ram_rdata;
        ram_we        = 1'b1;
        ram_waddr     = AW'(free_head_r);
        ram_wdata     = NIL;
        state_nxt     = ST_DONE;
      end
      ST_APP_LINK: begin
        ram_we     = 1'b1;
        ram_waddr  = AW'(q_tail);
        ram_wdata  = slot_r;
        q_tail_nxt = slot_r;
        state_nxt  = ST_DONE;
      end
      ST_RM_HEAD: begin
        if (is_slot(ram_rdata)) begin
          q_head_nxt = ram_rdata;
        end else begin
          q_head_nxt = NIL;
          q_tail_nxt = NIL;
        end
        ram_we    = 1'b1;
        ram_waddr = AW'(slot_r);
        ram_wdata = NIL;
        state_nxt = ST_DONE;
      end
      ST_RM_WALK: begin
        if (!is_slot(ram_rdata)) begin
          res_status_nxt = STATUS_NOTFOUND;
          state_nxt      = ST_DONE;
        end else if (ram_rdata == slot_r) begin
          if (q_tail == slot_r) begin
            q_tail_nxt = cur_r;
          end
          ram_raddr = AW'(slot_r);
          state_nxt = ST_RM_SRD;
        end else if (steps_r == AW'(SLOTS - 1)) begin
          res_status_nxt = STATUS_NOTFOUND;
          state_nxt      = ST_DONE;
        end else begin
          steps_nxt = steps_r + AW'(1);
          cur_nxt   = ram_rdata;
          ram_raddr = AW'(ram_rdata);
        end
      end
      ST_RM_SRD: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(cur_r);
        ram_wdata = ram_rdata;
        state_nxt = ST_RM_FIX;
      end
      ST_RM_FIX: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(slot_r);
        ram_wdata = NIL;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    run_head_nxt = run_head_r;
    run_tail_nxt = run_tail_r;
    blk_head_nxt = blk_head_r;
    blk_tail_nxt = blk_tail_r;
    if (blk_sel) begin
      blk_head_nxt = q_head_nxt;
      blk_tail_nxt = q_tail_nxt;
    end else begin
      run_head_nxt = q_head_nxt;
      run_tail_nxt = q_tail_nxt;
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if ((state_r == ST_DONE) && (!out_valid_r || out_tready)) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_slot_nxt   = res_slot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      free_head_r <= '0;
      run_head_r  <= NIL;
      run_tail_r  <= NIL;
      blk_head_r  <= NIL;
      blk_tail_r  <= NIL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      free_head_r <= free_head_nxt;
      run_head_r  <= run_head_nxt;
      run_tail_r  <= run_tail_nxt;
      blk_head_r  <= blk_head_nxt;
      blk_tail_r  <= blk_tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qblk_r       <= qblk_nxt;
    slot_r       <= slot_nxt;
    cur_r        <= cur_nxt;
    steps_r      <= steps_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_slot_r, out_status_r};

endmodule

FILE: hdl/tspqm_checker.sv
// Port-level checker for the task slot pool and queue manager, bound to the top level.
// Depends on tspqm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tspqm_checker
  import tspqm_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  `ASSERT_CLK_RST(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")
  `ASSERT_CLK_RST(a_one_request, clk, rst_n, in_tvalid && in_tready |=> !in_tready, "second request taken while busy")
  `ASSERT_CLK_RST(a_status_code, clk, rst_n, out_tvalid |-> out_tdata[1:0] != 2'b11, "undefined status code")
  `ASSERT_CLK_RST(a_empty_slot, clk, rst_n, out_tvalid && out_tdata[1:0] == STATUS_EMPTY |-> out_tdata[5:2] == 4'd0, "empty pool result carries a slot")
  `ASSERT_CLK_RST(a_alloc_ok, clk, rst_n, in_tvalid && in_tready && in_tdata[2:0] == ACT_ALLOC |=> !out_tvalid || out_tdata[1:0] != STATUS_NOTFOUND || $past(out_tvalid), "allocate reported not found")

endmodule

bind task_slot_pool_queue_manager tspqm_checker u_tspqm_checker (.*);
